@@ design/fdsa_pkg.sv @@
// Shared types, constants and helpers of the file directory sector allocator.
// Depends on nothing; every module of the block imports it.
package fdsa_pkg;

   localparam int DIR_ENTRIES_DEF      = 16;
   localparam int SECTORS_PER_FILE_DEF = 26;
   localparam int NUM_SECTORS_DEF      = 256;
   localparam int MAX_RESULTS          = 26;
   localparam int PTR_W                = 9;
   localparam logic [7:0] RESERVED_RESET = 8'd3;
   localparam logic [7:0] NEWLINE_BYTE   = 8'h0A;

   localparam logic [1:0] KIND_CREATE = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_DELETE = 2'd2;
   localparam logic [1:0] KIND_LIST   = 2'd3;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_DIR_FULL  = 2'd2;
   localparam logic [1:0] STATUS_NO_SPACE  = 2'd3;

   typedef struct packed {
      logic [1:0]  kind;
      logic [47:0] file_name;
      logic [4:0]  sector_count;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  entry_index;
      logic [7:0]  sector_number;
      logic        sector_valid;
      logic [4:0]  position;
      logic [47:0] name_out;
      logic [4:0]  count_out;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      logic       set;
      logic       clr;
      logic [7:0] idx;
   } map_op_type;

   // Keep name bytes up to the first zero or newline byte, zero the rest.
   function automatic logic [47:0] stored_name(input logic [47:0] name);
      logic [47:0] res;
      logic        stop;
      logic [7:0]  b;
      res  = '0;
      stop = 1'b0;
      for (int i = 0; i < 6; i++) begin
         b = name[8*i +: 8];
         if (b == 8'd0 || b == NEWLINE_BYTE) begin
            stop = 1'b1;
         end
         if (!stop) begin
            res[8*i +: 8] = b;
         end
      end
      return res;
   endfunction

endpackage

@@ design/fdsa_sector_map.sv @@
// Sector-use bitmap with the first-free search unit.
// Depends on fdsa_pkg.
module fdsa_sector_map import fdsa_pkg::*; #(
   parameter int NUM_SECTORS = NUM_SECTORS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  map_op_type       map_op,
   input  logic [PTR_W-1:0] search_ptr,
   output logic             found,
   output logic [7:0]       pick
);

   localparam int SW    = $clog2(NUM_SECTORS);
   localparam int PAD_W = 2 ** PTR_W;

   logic [NUM_SECTORS-1:0] used_ff;
   logic [NUM_SECTORS-1:0] used_in;
   logic [PAD_W-1:0]       free_pad;
   logic [7:0]             cand;
   logic [2:0]             low;

   always_comb begin
      used_in = used_ff;
      if (int'(map_op.idx) < NUM_SECTORS) begin
         if (map_op.set) begin
            used_in[map_op.idx[SW-1:0]] = 1'b1;
         end else if (map_op.clr) begin
            used_in[map_op.idx[SW-1:0]] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
   end

   // Sectors past the end of the disk read as taken.
   always_comb begin
      free_pad = '0;
      for (int i = 0; i < NUM_SECTORS; i++) begin
         free_pad[i] = !used_ff[i];
      end
   end

   assign cand = free_pad[search_ptr[PTR_W-1:3]*8 +: 8] & (8'hFF << search_ptr[2:0]);

   always_comb begin
      low = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (cand[i]) begin
            low = 3'(i);
         end
      end
   end

   assign found = |cand;
   assign pick  = {search_ptr[7:3], low};

endmodule

@@ design/fdsa_sector_store.sv @@
// Per-entry sector lists, a single address port for writes and registered reads.
// Depends on fdsa_pkg.
module fdsa_sector_store import fdsa_pkg::*; #(
   parameter int DEPTH = DIR_ENTRIES_DEF * SECTORS_PER_FILE_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic          rd_en,
   input  logic [AW-1:0] addr,
   input  logic [7:0]    wr_data,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/file_directory_sector_allocator.sv @@
// Top level of the file directory sector allocator: sequencer and name table.
// Depends on fdsa_pkg, fdsa_sector_map and fdsa_sector_store.
//
//   channel | ports                  | moves
//   --------+------------------------+--------------------------------------
//   request | req_valid/ready/data   | one command item (create/lookup/...)
//   result  | rsp_valid/ready/data   | result items, last marks the final one
//   csr     | csr_valid/ready/data   | reserved_below, always ready
//
// One item at a time; req_ready is high only in the idle step. Create: search the
// map for free sectors, picking one sector or skipping a group of eight map bits
// per step, scan for a free entry, write the whole row of SECTORS_PER_FILE
// sectors, then emit one result per sector. Lookup/delete: scan the entries,
// count the stored list with a registered store read per sector, then read each
// sector back and emit or free it.
// List: count used entries, then per used entry a scan, a count pass and one
// emit step.
// Reset clears the map, names and control; the sector store needs no clear,
// since a row is always written by create before it is read.
// A stalled result holds the sequencer in its emit step; the next item is
// taken as soon as the last result sits in the output register.
module file_directory_sector_allocator import fdsa_pkg::*; #(
   parameter int DIR_ENTRIES      = DIR_ENTRIES_DEF,
   parameter int SECTORS_PER_FILE = SECTORS_PER_FILE_DEF,
   parameter int NUM_SECTORS      = NUM_SECTORS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_data
);

   localparam int CAP   = (SECTORS_PER_FILE < MAX_RESULTS) ? SECTORS_PER_FILE : MAX_RESULTS;
   localparam int EW    = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
   localparam int ECW   = $clog2(DIR_ENTRIES + 1);
   localparam int JW    = $clog2(SECTORS_PER_FILE + 1);
   localparam int PIW   = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int DEPTH = DIR_ENTRIES * SECTORS_PER_FILE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW    = 7;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_C_SRCH  = 4'd1;
   localparam logic [3:0] S_C_DIR   = 4'd2;
   localparam logic [3:0] S_C_WR    = 4'd3;
   localparam logic [3:0] S_C_EMIT  = 4'd4;
   localparam logic [3:0] S_F_SCAN  = 4'd5;
   localparam logic [3:0] S_CNT_A   = 4'd6;
   localparam logic [3:0] S_CNT_D   = 4'd7;
   localparam logic [3:0] S_L_A     = 4'd8;
   localparam logic [3:0] S_L_D     = 4'd9;
   localparam logic [3:0] S_D_A     = 4'd10;
   localparam logic [3:0] S_D_D     = 4'd11;
   localparam logic [3:0] S_LS_U    = 4'd12;
   localparam logic [3:0] S_LS_SCAN = 4'd13;
   localparam logic [3:0] S_LS_EMIT = 4'd14;
   localparam logic [3:0] S_ONE     = 4'd15;

   logic [3:0]       state_ff, state_in;
   logic [1:0]       kind_ff, kind_in;
   logic [47:0]      name_ff, name_in;
   logic [JW-1:0]    n_ff, n_in;
   logic [JW-1:0]    got_ff, got_in;
   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [ECW-1:0]   e_ff, e_in;
   logic [JW-1:0]    j_ff, j_in;
   logic [JW-1:0]    cnt_ff, cnt_in;
   logic [LW-1:0]    k_ff, k_in;
   logic [LW-1:0]    u_ff, u_in;
   logic [1:0]       st_ff, st_in;
   logic [7:0]       reserved_ff, reserved_in;
   logic [7:0]       pick_ff [CAP];
   logic             pick_we;
   logic [47:0]      names_ff [DIR_ENTRIES];
   logic             name_we;
   logic [47:0]      name_wdata;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_item_type     rsp_data_ff, rsp_data_in;

   logic             rsp_ok;
   logic [EW-1:0]    e_idx;
   logic             e_used;
   logic [LW-1:0]    lim;
   logic [JW-1:0]    look_n;
   logic [JW-1:0]    want;

   map_op_type       map_op;
   logic             map_found;
   logic [7:0]       map_pick;
   logic             st_we, st_re;
   logic [AW-1:0]    st_addr;
   logic [7:0]       st_wdata, st_rdata;

   fdsa_sector_map #(.NUM_SECTORS(NUM_SECTORS)) u_map (
      .clock      (clock),
      .reset      (reset),
      .map_op     (map_op),
      .search_ptr (ptr_ff),
      .found      (map_found),
      .pick       (map_pick)
   );

   fdsa_sector_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .rd_en   (st_re),
      .addr    (st_addr),
      .wr_data (st_wdata),
      .rd_data (st_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign rsp_ok    = !rsp_valid_ff || rsp_ready;

   assign e_idx   = e_ff[EW-1:0];
   assign e_used  = (int'(e_ff) < DIR_ENTRIES) && (names_ff[e_idx][7:0] != 8'd0);
   assign lim     = (int'(u_ff) > MAX_RESULTS) ? LW'(MAX_RESULTS) : u_ff;
   assign look_n  = (int'(cnt_ff) > MAX_RESULTS) ? JW'(MAX_RESULTS) : cnt_ff;
   assign want    = (int'(req_data.sector_count) > CAP) ? JW'(CAP)
                                                         : JW'(req_data.sector_count);
   assign st_addr = AW'(AW'(e_idx) * AW'(SECTORS_PER_FILE) + AW'(j_ff));
   assign st_wdata = (j_ff < n_ff) ? pick_ff[j_ff[PIW-1:0]] : 8'd0;
   assign reserved_in = csr_valid ? csr_data : reserved_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      name_in      = name_ff;
      n_in         = n_ff;
      got_in       = got_ff;
      ptr_in       = ptr_ff;
      e_in         = e_ff;
      j_in         = j_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      u_in         = u_ff;
      st_in        = st_ff;
      pick_we      = 1'b0;
      name_we      = 1'b0;
      name_wdata   = '0;
      map_op       = '0;
      st_we        = 1'b0;
      st_re        = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in = req_data.kind;
               name_in = req_data.file_name;
               n_in    = want;
               got_in  = '0;
               e_in    = '0;
               j_in    = '0;
               k_in    = '0;
               u_in    = '0;
               ptr_in  = (reserved_ff == 8'd0) ? PTR_W'(1) : PTR_W'(reserved_ff);
               priority case (req_data.kind)
                  KIND_CREATE: state_in = S_C_SRCH;
                  KIND_LIST:   state_in = S_LS_U;
                  default:     state_in = S_F_SCAN;
               endcase
            end
         end
         S_C_SRCH: begin
            // Collect the lowest free sectors; leave the map untouched until done.
            if (got_ff == n_ff) begin
               state_in = S_C_DIR;
            end else if (int'(ptr_ff) >= NUM_SECTORS) begin
               st_in    = STATUS_NO_SPACE;
               e_in     = '0;
               state_in = S_ONE;
            end else if (map_found) begin
               pick_we = 1'b1;
               got_in  = got_ff + JW'(1);
               ptr_in  = PTR_W'(map_pick) + PTR_W'(1);
            end else begin
               ptr_in = {ptr_ff[PTR_W-1:3] + (PTR_W-3)'(1), 3'd0};
            end
         end
         S_C_DIR: begin
            if (int'(e_ff) >= DIR_ENTRIES) begin
               st_in    = STATUS_DIR_FULL;
               e_in     = '0;
               state_in = S_ONE;
            end else if (!e_used) begin
               name_we    = 1'b1;
               name_wdata = stored_name(name_ff);
               j_in       = '0;
               state_in   = S_C_WR;
            end else begin
               e_in = e_ff + ECW'(1);
            end
         end
         S_C_WR: begin
            // Write the whole row, mark picked sectors used.
            st_we = 1'b1;
            if (j_ff < n_ff) begin
               map_op.set = 1'b1;
               map_op.idx = st_wdata;
            end
            if (int'(j_ff) == SECTORS_PER_FILE - 1) begin
               j_in     = '0;
               state_in = S_C_EMIT;
            end else begin
               j_in = j_ff + JW'(1);
            end
         end
         S_C_EMIT: begin
            if (rsp_ok) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = '0;
               rsp_data_in.status      = STATUS_OK;
               rsp_data_in.entry_index = 4'(e_ff);
               if (n_ff == '0) begin
                  rsp_data_in.last = 1'b1;
                  state_in         = S_IDLE;
               end else begin
                  rsp_data_in.sector_number = pick_ff[j_ff[PIW-1:0]];
                  rsp_data_in.sector_valid  = 1'b1;
                  rsp_data_in.position      = 5'(j_ff);
                  rsp_data_in.last          = (j_ff + JW'(1) == n_ff);
                  j_in                      = j_ff + JW'(1);
                  if (j_ff + JW'(1) == n_ff) begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_F_SCAN: begin
            if (int'(e_ff) >= DIR_ENTRIES) begin
               st_in    = STATUS_NOT_FOUND;
               e_in     = '0;
               state_in = S_ONE;
            end else if (e_used && names_ff[e_idx] == name_ff) begin
               j_in     = '0;
               state_in = S_CNT_A;
            end else begin
               e_in = e_ff + ECW'(1);
            end
         end
         S_CNT_A: begin
            st_re    = 1'b1;
            state_in = S_CNT_D;
         end
         S_CNT_D: begin
            // A zero sector or the end of the row ends the list; then branch on the command.
            if (st_rdata == 8'd0 || int'(j_ff) == SECTORS_PER_FILE - 1) begin
               cnt_in = (st_rdata == 8'd0) ? j_ff : JW'(SECTORS_PER_FILE);
               j_in   = '0;
               priority case (kind_ff)
                  KIND_LOOKUP: state_in = S_L_A;
                  KIND_DELETE: state_in = S_D_A;
                  default:     state_in = S_LS_EMIT;
               endcase
            end else begin
               j_in     = j_ff + JW'(1);
               state_in = S_CNT_A;
            end
         end
         S_L_A: begin
            if (cnt_ff == '0) begin
               st_in    = STATUS_OK;
               state_in = S_ONE;
            end else begin
               st_re    = 1'b1;
               state_in = S_L_D;
            end
         end
         S_L_D: begin
            if (rsp_ok) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in                = '0;
               rsp_data_in.status         = STATUS_OK;
               rsp_data_in.entry_index    = 4'(e_ff);
               rsp_data_in.sector_number  = st_rdata;
               rsp_data_in.sector_valid   = 1'b1;
               rsp_data_in.position       = 5'(j_ff);
               rsp_data_in.last           = (j_ff + JW'(1) == look_n);
               j_in                       = j_ff + JW'(1);
               state_in = (j_ff + JW'(1) == look_n) ? S_IDLE : S_L_A;
            end
         end
         S_D_A: begin
            if (j_ff == cnt_ff) begin
               name_we    = 1'b1;
               name_wdata = '0;
               st_in      = STATUS_OK;
               state_in   = S_ONE;
            end else begin
               st_re    = 1'b1;
               state_in = S_D_D;
            end
         end
         S_D_D: begin
            map_op.clr = 1'b1;
            map_op.idx = st_rdata;
            j_in       = j_ff + JW'(1);
            state_in   = S_D_A;
         end
         S_LS_U: begin
            // Count used entries first so the last list result is known.
            if (int'(e_ff) >= DIR_ENTRIES) begin
               e_in = '0;
               if (u_ff == '0) begin
                  st_in    = STATUS_NOT_FOUND;
                  state_in = S_ONE;
               end else begin
                  state_in = S_LS_SCAN;
               end
            end else begin
               if (e_used) begin
                  u_in = u_ff + LW'(1);
               end
               e_in = e_ff + ECW'(1);
            end
         end
         S_LS_SCAN: begin
            if (e_used) begin
               j_in     = '0;
               state_in = S_CNT_A;
            end else begin
               e_in = e_ff + ECW'(1);
            end
         end
         S_LS_EMIT: begin
            if (rsp_ok) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = '0;
               rsp_data_in.status      = STATUS_OK;
               rsp_data_in.entry_index = 4'(e_ff);
               rsp_data_in.name_out    = names_ff[e_idx];
               rsp_data_in.count_out   = (int'(cnt_ff) > 31) ? 5'd31 : 5'(cnt_ff);
               rsp_data_in.last        = (k_ff + LW'(1) == lim);
               k_in                    = k_ff + LW'(1);
               e_in                    = e_ff + ECW'(1);
               state_in = (k_ff + LW'(1) == lim) ? S_IDLE : S_LS_SCAN;
            end
         end
         S_ONE: begin
            if (rsp_ok) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = '0;
               rsp_data_in.status      = st_ff;
               rsp_data_in.entry_index = 4'(e_ff);
               rsp_data_in.last        = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         reserved_ff  <= RESERVED_RESET;
         for (int i = 0; i < DIR_ENTRIES; i++) begin
            names_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         reserved_ff  <= reserved_in;
         if (name_we) begin
            names_ff[e_idx] <= name_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      name_ff     <= name_in;
      n_ff        <= n_in;
      got_ff      <= got_in;
      ptr_ff      <= ptr_in;
      e_ff        <= e_in;
      j_ff        <= j_in;
      cnt_ff      <= cnt_in;
      k_ff        <= k_in;
      u_ff        <= u_in;
      st_ff       <= st_in;
      rsp_data_ff <= rsp_data_in;
      if (pick_we) begin
         pick_ff[got_ff[PIW-1:0]] <= map_pick;
      end
   end

endmodule

@@ verif/tb.sv @@
// Self-checking testbench of file_directory_sector_allocator.
// Depends on fdsa_pkg and the block's RTL; predicts every result item itself.
`timescale 1ns / 1ps

module tb;
   import fdsa_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [7:0]   csr_data;

   // Mirror of the directory, the sector map and the bound.
   logic [47:0] dir_name [16];
   logic [7:0]  dir_sector [16][26];
   logic        map_used [256];
   logic [7:0]  bound;

   rsp_item_type pending_results[$];
   int errors;
   int items_sent;
   int results_seen;
   int hold_cycles;
   int stall_max;

   file_directory_sector_allocator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   // Queue one expected result item.
   task automatic push_result(logic [1:0] st, int idx, logic [7:0] sec, logic sv, int pos,
                              logic [47:0] nm, int cnt, logic lst);
      rsp_item_type r;
      r.status        = st;
      r.entry_index   = idx[3:0];
      r.sector_number = sec;
      r.sector_valid  = sv;
      r.position      = pos[4:0];
      r.name_out      = nm;
      r.count_out     = cnt[4:0];
      r.last          = lst;
      pending_results.push_back(r);
   endtask

   function automatic int file_length(int e);
      int n;
      n = 0;
      while (n < 26 && dir_sector[e][n] != 8'd0) n++;
      return n;
   endfunction

   function automatic int find_file(logic [47:0] nm);
      for (int e = 0; e < 16; e++) begin
         if (dir_name[e][7:0] != 8'd0 && dir_name[e] == nm) return e;
      end
      return -1;
   endfunction

   // Advance the mirror by one accepted item and queue what it must produce.
   task automatic predict_directory(req_item_type it);
      logic [7:0]  picked [26];
      logic [47:0] kept;
      logic        stop;
      logic [7:0]  b;
      int want, got, slot, e, n, k;
      case (it.kind)
         KIND_CREATE: begin
            want = (it.sector_count > 26) ? 26 : it.sector_count;
            got  = 0;
            for (int s = (bound != 0) ? bound : 1; s < 256 && got < want; s++) begin
               if (!map_used[s]) begin
                  picked[got] = s[7:0];
                  got++;
               end
            end
            slot = -1;
            for (int i = 0; i < 16 && slot < 0; i++) begin
               if (dir_name[i][7:0] == 8'd0) slot = i;
            end
            if (got < want) begin
               push_result(STATUS_NO_SPACE, 0, 0, 0, 0, 0, 0, 1);
            end else if (slot < 0) begin
               push_result(STATUS_DIR_FULL, 0, 0, 0, 0, 0, 0, 1);
            end else begin
               // copy name bytes until a zero or newline byte
               kept = '0;
               stop = 1'b0;
               for (int j = 0; j < 6; j++) begin
                  b = it.file_name[8*j +: 8];
                  if (b == 8'd0 || b == NEWLINE_BYTE) stop = 1'b1;
                  if (!stop) kept[8*j +: 8] = b;
               end
               dir_name[slot] = kept;
               for (int j = 0; j < 26; j++) dir_sector[slot][j] = (j < want) ? picked[j] : 8'd0;
               for (int j = 0; j < want; j++) map_used[picked[j]] = 1'b1;
               if (want == 0) push_result(STATUS_OK, slot, 0, 0, 0, 0, 0, 1);
               for (int j = 0; j < want; j++)
                  push_result(STATUS_OK, slot, picked[j], 1, j, 0, 0, j == want - 1);
            end
         end
         KIND_LIST: begin
            k = 0;
            for (int i = 0; i < 16 && k < 26; i++) begin
               if (dir_name[i][7:0] != 8'd0) begin
                  push_result(STATUS_OK, i, 0, 0, 0, dir_name[i], file_length(i), 0);
                  k++;
               end
            end
            if (k == 0) push_result(STATUS_NOT_FOUND, 0, 0, 0, 0, 0, 0, 1);
            else pending_results[$].last = 1'b1;
         end
         default: begin
            e = find_file(it.file_name);
            if (e < 0) begin
               push_result(STATUS_NOT_FOUND, 0, 0, 0, 0, 0, 0, 1);
            end else begin
               n = file_length(e);
               if (it.kind == KIND_DELETE) begin
                  for (int j = 0; j < n; j++) map_used[dir_sector[e][j]] = 1'b0;
                  dir_name[e] = '0;
                  push_result(STATUS_OK, e, 0, 0, 0, 0, 0, 1);
               end else if (n == 0) begin
                  push_result(STATUS_OK, e, 0, 0, 0, 0, 0, 1);
               end else begin
                  for (int j = 0; j < n; j++)
                     push_result(STATUS_OK, e, dir_sector[e][j], 1, j, 0, 0, j == n - 1);
               end
            end
         end
      endcase
   endtask

   // Send one item. Entered at a falling edge; returns at the falling edge after
   // acceptance, where the caller must either drive the next item or drop valid.
   task automatic send_item(logic [1:0] kind, logic [47:0] nm, logic [4:0] cnt);
      req_item_type it;
      int gap;
      it.kind         = kind;
      it.file_name    = nm;
      it.sector_count = cnt;
      gap = $urandom_range(0, stall_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (!req_ready);
      predict_directory(it);
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_bound(logic [7:0] v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      bound = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [47:0] random_name();
      logic [47:0] nm;
      int pos;
      for (int j = 0; j < 6; j++) nm[8*j +: 8] = 8'($urandom_range(1, 255));
      if ($urandom_range(0, 5) == 0) begin
         pos = $urandom_range(0, 5);
         nm[8*pos +: 8] = $urandom_range(0, 1) ? NEWLINE_BYTE : 8'd0;
      end
      if ($urandom_range(0, 19) == 0) nm[7:0] = 8'd0;
      return nm;
   endfunction

   // Pick a stored name, or a fresh random one when the directory is empty.
   function automatic logic [47:0] existing_name();
      int live [$];
      for (int i = 0; i < 16; i++) if (dir_name[i][7:0] != 8'd0) live.push_back(i);
      if (live.size() == 0) return random_name();
      return dir_name[live[$urandom_range(0, live.size() - 1)]];
   endfunction

   // Receiver: drop ready for a random gap bounded by stall_max before each item, with an occasional long hold.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end else begin
            gap = $urandom_range(0, stall_max);
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            rsp_ready <= 1'b1;
            do @(posedge clock); while (!(rsp_valid && rsp_ready));
            @(negedge clock);
         end
      end
   end

   // Compare each accepted result item against the oldest expectation.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result item %h", $time, rsp_data);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status || rsp_data.entry_index !== want.entry_index ||
                rsp_data.sector_number !== want.sector_number ||
                rsp_data.sector_valid !== want.sector_valid ||
                rsp_data.position !== want.position || rsp_data.name_out !== want.name_out ||
                rsp_data.count_out !== want.count_out || rsp_data.last !== want.last) begin
               errors++;
               $display("%0t: mismatch expected st=%0d idx=%0d sec=%0d sv=%0d pos=%0d name=%h cnt=%0d last=%0d",
                        $time, want.status, want.entry_index, want.sector_number,
                        want.sector_valid, want.position, want.name_out, want.count_out, want.last);
               $display("%0t:          actual   st=%0d idx=%0d sec=%0d sv=%0d pos=%0d name=%h cnt=%0d last=%0d",
                        $time, rsp_data.status, rsp_data.entry_index, rsp_data.sector_number,
                        rsp_data.sector_valid, rsp_data.position, rsp_data.name_out,
                        rsp_data.count_out, rsp_data.last);
            end
         end
      end
   end

   // Empty directory: list, lookup and delete all miss.
   task automatic test_empty_directory();
      send_item(KIND_LIST, 48'h0, 5'd0);
      send_item(KIND_LOOKUP, 48'h313233343536, 5'd0);
      send_item(KIND_DELETE, 48'hFFFF_FFFF_FFFF, 5'd31);
   endtask

   // Field extremes, name truncation, saturation, empty files, delete.
   task automatic test_create_lookup();
      send_item(KIND_CREATE, 48'h414141414141, 5'd0);    // empty file
      send_item(KIND_LOOKUP, 48'h414141414141, 5'd0);
      send_item(KIND_CREATE, 48'hFFFF_FFFF_FFFF, 5'd26);
      send_item(KIND_CREATE, 48'h424242424242, 5'd31);   // saturates to 26
      send_item(KIND_CREATE, 48'h4343_0A43_4343, 5'd3);  // newline cuts name
      send_item(KIND_CREATE, 48'h4444_4400_4444, 5'd2);  // zero byte cuts name
      send_item(KIND_CREATE, 48'h5555_5555_5500, 5'd4);  // empty name, sectors leak
      send_item(KIND_LOOKUP, 48'h0000_0000_4343, 5'd0);
      send_item(KIND_LOOKUP, 48'hFFFF_FFFF_FFFF, 5'd0);
      send_item(KIND_LIST, 48'h0, 5'd0);
      send_item(KIND_DELETE, 48'h424242424242, 5'd0);
      send_item(KIND_CREATE, 48'h464646464646, 5'd5);    // reuses freed sectors
      send_item(KIND_LOOKUP, 48'h464646464646, 5'd0);
      send_item(KIND_DELETE, 48'h424242424242, 5'd0);
   endtask

   // Fill all entries, hit directory full, list all sixteen, then clean up.
   task automatic test_directory_full();
      for (int i = 0; i < 16; i++) send_item(KIND_CREATE, 48'h6000 + i, 5'd1);
      send_item(KIND_LIST, 48'h0, 5'd0);
      for (int i = 0; i < 16; i++) send_item(KIND_DELETE, 48'h6000 + i, 5'd0);
      for (int i = 0; i < 16; i++) send_item(KIND_DELETE, existing_name(), 5'd0);
   endtask

   // Bound extremes: only sector 255 free, then bound zero.
   task automatic test_bound_extremes();
      write_bound(8'd255);
      send_item(KIND_CREATE, 48'h707070707070, 5'd1);
      send_item(KIND_CREATE, 48'h717171717171, 5'd1);    // no space
      send_item(KIND_CREATE, 48'h727272727272, 5'd0);
      write_bound(8'd0);
      send_item(KIND_CREATE, 48'h737373737373, 5'd3);
      send_item(KIND_LIST, 48'h0, 5'd0);
      write_bound(8'd200);
      send_item(KIND_CREATE, 48'h747474747474, 5'd26);   // fits in the free sectors at and above the bound
   endtask

   // Hold the result side long enough for the block to stall its input.
   task automatic test_backpressure();
      wait_idle();
      hold_cycles = 400;
      for (int i = 0; i < 6; i++)
         send_item(KIND_CREATE, random_name(), 5'($urandom_range(1, 6)));
      send_item(KIND_LIST, 48'h0, 5'd0);
   endtask

   task automatic test_random_traffic(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         stall_max = ((i / 20) % 3 == 1) ? 0 : 5;
         pick = $urandom_range(0, 99);
         if (pick < 38)
            send_item(KIND_CREATE, random_name(),
                      ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                  : 5'($urandom_range(0, 8)));
         else if (pick < 60)
            send_item(KIND_LOOKUP, ($urandom_range(0, 4) == 0) ? random_name() : existing_name(),
                      5'($urandom_range(0, 31)));
         else if (pick < 86)
            send_item(KIND_DELETE, ($urandom_range(0, 4) == 0) ? random_name() : existing_name(),
                      5'($urandom_range(0, 31)));
         else
            send_item(KIND_LIST, random_name(), 5'($urandom_range(0, 31)));
         if (i == count / 2) write_bound(8'($urandom_range(1, 40)));
      end
      write_bound(RESERVED_RESET);
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      errors      = 0;
      items_sent  = 0;
      results_seen = 0;
      hold_cycles = 0;
      stall_max   = 5;
      bound       = RESERVED_RESET;
      for (int i = 0; i < 16; i++) begin
         dir_name[i] = '0;
         for (int j = 0; j < 26; j++) dir_sector[i][j] = 8'd0;
      end
      for (int s = 0; s < 256; s++) map_used[s] = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_directory();
      test_create_lookup();
      test_directory_full();
      test_bound_extremes();
      test_backpressure();
      test_random_traffic(40);
      wait_idle();

      $display("Covered %0d request items and %0d result items: create/lookup/delete/list,",
               items_sent, results_seen);
      $display("full directory, no space, name truncation and bounds 0, 3, 200 and 255.");
      if (errors == 0 && pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
